>>> rtl/tcwc_pkg.sv
// Package with the types, constants and helper functions of the congestion window control unit.
`timescale 1ns / 1ps

package tcwc_pkg;

    // Field and state widths.
    localparam int SEQ_BITS  = 16;
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int INT_W     = Q_W - FRAC_BITS;
    localparam int THR_W     = 16;
    localparam int CNT_W     = 16;
    localparam int DUP_W     = 8;
    localparam int FLIGHT_W  = 18;
    localparam int FL_EXT_W  = FLIGHT_W + 2;
    localparam int WIDE_W    = Q_W + THR_W + 2;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int DIV_CNT_W = $clog2(Q_W);

    // Operation codes of an event.
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SEGMENTS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD = 1'b1;

    // Protocol constants.
    localparam logic [THR_W-1:0] INIT_THRESHOLD  = 16'd6;
    localparam logic [THR_W-1:0] THR_FLOOR       = 16'd2;
    localparam logic [THR_W-1:0] RECOVERY_INFLATE = 16'd3;
    localparam logic [THR_W-1:0] THR_MAX         = '1;
    localparam logic [DUP_W-1:0] DUP_MAX         = '1;
    localparam logic [DUP_W-1:0] DUP_TRIGGER     = 8'd3;

    localparam logic [Q_W-1:0] ONE_Q  = Q_W'(64'd1 << FRAC_BITS);
    localparam logic [Q_W-1:0] FOUR_Q = Q_W'(64'd4 << FRAC_BITS);
    localparam logic [Q_W-1:0] Q_MAX  = '1;

    localparam logic signed [FLIGHT_W-1:0] FLIGHT_MAX = {1'b0, {(FLIGHT_W-1){1'b1}}};
    localparam logic signed [FLIGHT_W-1:0] FLIGHT_MIN = {1'b1, {(FLIGHT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_ACCUM,
        S_BURST
    } t_state;

    // Clamp a wide unsigned sum to the window range.
    function automatic logic [Q_W-1:0] sat_q(input logic [WIDE_W-1:0] v);
        logic [Q_W-1:0] res;
        if (v > WIDE_W'(Q_MAX)) begin
            res = Q_MAX;
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

    // Clamp a widened in-flight count back to its signed range.
    function automatic logic signed [FLIGHT_W-1:0] sat_flight(
        input logic signed [FL_EXT_W-1:0] v
    );
        logic signed [FLIGHT_W-1:0] res;
        if (v > FL_EXT_W'(FLIGHT_MAX)) begin
            res = FLIGHT_MAX;
        end else if (v < FL_EXT_W'(FLIGHT_MIN)) begin
            res = FLIGHT_MIN;
        end else begin
            res = v[FLIGHT_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/tcwc_evt_if.sv
// Interface of the event channel: valid, ready and the event fields.
`timescale 1ns / 1ps

interface tcwc_evt_if;
    logic                          valid;
    logic                          ready;
    logic [tcwc_pkg::OP_W-1:0]     operation;
    logic [tcwc_pkg::SEQ_BITS-1:0] ack_number;

    modport source (output valid, output operation, output ack_number, input ready);
    modport sink (input valid, input operation, input ack_number, output ready);
endinterface

>>> rtl/tcwc_res_if.sv
// Interface of the result channel: valid, ready and the result fields.
`timescale 1ns / 1ps

interface tcwc_res_if;
    logic                          valid;
    logic                          ready;
    logic [tcwc_pkg::SEQ_BITS-1:0] send_start;
    logic [tcwc_pkg::CNT_W-1:0]    send_count;
    logic                          retransmit;
    logic [tcwc_pkg::SEQ_BITS-1:0] retransmit_seq;
    logic [tcwc_pkg::INT_W-1:0]    window_size;
    logic [tcwc_pkg::THR_W-1:0]    threshold;

    modport source (
        output valid, output send_start, output send_count, output retransmit,
        output retransmit_seq, output window_size, output threshold, input ready
    );
    modport sink (
        input valid, input send_start, input send_count, input retransmit,
        input retransmit_seq, input window_size, input threshold, output ready
    );
endinterface

>>> rtl/tcp_congestion_window_control_unit.sv
// Top level of the congestion window control unit: sequencer, restoring divider and state.
// An event is accepted in IDLE, applied in EXEC, and its result registered in BURST once
// the output register is free; a congestion-avoidance acknowledgment passes through the DIV
// iterations of the restoring divider (skipped when the step saturates) and ACCUM before BURST.
// A new event is accepted only after the result of the previous one has been registered.
// Reset (synchronous, active low) restores the window to one segment and the threshold to 6.
`timescale 1ns / 1ps

module tcp_congestion_window_control_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tcwc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcwc_pkg::CFG_W-1:0]         i_cfg_data,
    tcwc_evt_if.sink                           i_evt,
    tcwc_res_if.source                         o_res
);

    // Sequencer
    tcwc_pkg::t_state r_state, n_state;

    // Configuration
    logic [tcwc_pkg::SEQ_BITS-1:0] r_total_segments;

    // Protocol state
    logic [tcwc_pkg::Q_W-1:0]             r_window_q, n_window_q;
    logic [tcwc_pkg::THR_W-1:0]           r_slow_threshold, n_slow_threshold;
    logic [tcwc_pkg::DUP_W-1:0]           r_dup_count, n_dup_count;
    logic                                 r_in_recovery, n_in_recovery;
    logic [tcwc_pkg::SEQ_BITS-1:0]        r_last_ack, n_last_ack;
    logic [tcwc_pkg::SEQ_BITS-1:0]        r_window_base, n_window_base;
    logic signed [tcwc_pkg::FLIGHT_W-1:0] r_in_flight, n_in_flight;

    // Event being worked on
    logic [tcwc_pkg::OP_W-1:0]     r_op;
    logic [tcwc_pkg::SEQ_BITS-1:0] r_ack;
    logic                          r_rtx, n_rtx;
    logic [tcwc_pkg::SEQ_BITS-1:0] r_rtx_seq, n_rtx_seq;

    // Restoring divider
    logic [tcwc_pkg::Q_W-1:0]       r_rem, n_rem;
    logic [tcwc_pkg::Q_W-1:0]       r_quot, n_quot;
    logic [tcwc_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    // Output register
    logic                          r_out_valid;
    logic [tcwc_pkg::SEQ_BITS-1:0] r_out_send_start;
    logic [tcwc_pkg::CNT_W-1:0]    r_out_send_count;
    logic                          r_out_retransmit;
    logic [tcwc_pkg::SEQ_BITS-1:0] r_out_retransmit_seq;
    logic [tcwc_pkg::INT_W-1:0]    r_out_window_size;
    logic [tcwc_pkg::THR_W-1:0]    r_out_threshold;

    // Sequencer outputs
    logic w_in_ready;
    logic w_commit;

    // Derived values
    logic                          w_accept;
    logic                          w_is_new;
    logic                          w_is_dup;
    logic                          w_avoid;
    logic                          w_div_sat;
    logic [tcwc_pkg::SEQ_BITS-1:0] w_adv;
    logic [tcwc_pkg::INT_W-1:0]    w_win_int;
    logic [tcwc_pkg::Q_W-1:0]      w_halved_raw;
    logic [tcwc_pkg::THR_W-1:0]    w_halved;
    logic [tcwc_pkg::DUP_W-1:0]    w_dup_inc;
    logic [tcwc_pkg::Q_W:0]        w_rem_shift;
    logic                          w_rem_ge;
    logic                          w_send;
    logic [tcwc_pkg::SEQ_BITS-1:0] w_left;
    logic [tcwc_pkg::CNT_W-1:0]    w_count;
    logic [tcwc_pkg::THR_W-1:0]    w_cfg_threshold;

    assign w_accept  = i_evt.valid && w_in_ready;
    assign w_adv     = r_ack - r_last_ack;
    assign w_win_int = r_window_q[tcwc_pkg::Q_W-1:tcwc_pkg::FRAC_BITS];
    assign w_is_new  = (r_op == tcwc_pkg::OP_ACK) && (r_ack > r_last_ack);
    assign w_is_dup  = (r_op == tcwc_pkg::OP_ACK) && (r_ack == r_last_ack);
    assign w_avoid   = w_is_new && !r_in_recovery
                       && (tcwc_pkg::Q_W'(w_win_int) > tcwc_pkg::Q_W'(r_slow_threshold));
    // An advance not below the window would give a step of 2^32 or more: saturate at once.
    assign w_div_sat = tcwc_pkg::Q_W'(w_adv) >= r_window_q;

    assign w_halved_raw = r_window_q >> (tcwc_pkg::FRAC_BITS + 1);
    always_comb begin
        if (r_window_q <= tcwc_pkg::FOUR_Q) begin
            w_halved = tcwc_pkg::THR_FLOOR;
        end else if (w_halved_raw > tcwc_pkg::Q_W'(tcwc_pkg::THR_MAX)) begin
            w_halved = tcwc_pkg::THR_MAX;
        end else begin
            w_halved = w_halved_raw[tcwc_pkg::THR_W-1:0];
        end
    end

    assign w_dup_inc = (r_dup_count != tcwc_pkg::DUP_MAX) ? r_dup_count + 1'b1 : r_dup_count;

    // One restoring division step: the quotient bit is the compare of the shifted remainder.
    assign w_rem_shift = {r_rem, 1'b0};
    assign w_rem_ge    = w_rem_shift >= {1'b0, r_window_q};

    // Burst sizing from the settled window.
    assign w_send = r_in_flight < $signed(tcwc_pkg::FL_EXT_W'(w_win_int));
    assign w_left = r_total_segments - r_window_base;
    always_comb begin
        if (r_window_base >= r_total_segments) begin
            w_count = '0;
        end else if (tcwc_pkg::Q_W'(w_win_int) < tcwc_pkg::Q_W'(w_left)) begin
            w_count = tcwc_pkg::CNT_W'(w_win_int);
        end else begin
            w_count = tcwc_pkg::CNT_W'(w_left);
        end
    end

    assign w_cfg_threshold = (i_cfg_data < tcwc_pkg::THR_FLOOR)
                             ? tcwc_pkg::THR_FLOOR : tcwc_pkg::THR_W'(i_cfg_data);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcwc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = tcwc_pkg::S_EXEC;
                end
            end
            tcwc_pkg::S_EXEC: begin
                if (w_avoid) begin
                    n_state = w_div_sat ? tcwc_pkg::S_ACCUM : tcwc_pkg::S_DIV;
                end else begin
                    n_state = tcwc_pkg::S_BURST;
                end
            end
            tcwc_pkg::S_DIV: begin
                if (r_div_cnt == '1) begin
                    n_state = tcwc_pkg::S_ACCUM;
                end
            end
            tcwc_pkg::S_ACCUM: begin
                n_state = tcwc_pkg::S_BURST;
            end
            tcwc_pkg::S_BURST: begin
                if (w_commit) begin
                    n_state = tcwc_pkg::S_IDLE;
                end
            end
            default: n_state = tcwc_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            tcwc_pkg::S_IDLE:  w_in_ready = 1'b1;
            tcwc_pkg::S_BURST: w_commit = !r_out_valid || o_res.ready;
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_window_q       = r_window_q;
        n_slow_threshold = r_slow_threshold;
        n_dup_count      = r_dup_count;
        n_in_recovery    = r_in_recovery;
        n_last_ack       = r_last_ack;
        n_window_base    = r_window_base;
        n_in_flight      = r_in_flight;
        n_rtx            = r_rtx;
        n_rtx_seq        = r_rtx_seq;
        n_rem            = r_rem;
        n_quot           = r_quot;
        n_div_cnt        = r_div_cnt;

        case (r_state)
            tcwc_pkg::S_EXEC: begin
                n_rtx     = 1'b0;
                n_rtx_seq = '0;
                n_div_cnt = '0;
                n_rem     = tcwc_pkg::Q_W'(w_adv);
                n_quot    = w_div_sat ? tcwc_pkg::Q_MAX : '0;
                if (w_is_new) begin
                    if (r_in_recovery) begin
                        n_window_q = tcwc_pkg::sat_q(
                            tcwc_pkg::WIDE_W'(r_slow_threshold) << tcwc_pkg::FRAC_BITS);
                        n_in_recovery = 1'b0;
                    end else if (!w_avoid) begin
                        n_window_q = tcwc_pkg::sat_q(tcwc_pkg::WIDE_W'(r_window_q)
                            + (tcwc_pkg::WIDE_W'(w_adv) << tcwc_pkg::FRAC_BITS));
                    end
                    n_in_flight = tcwc_pkg::sat_flight(
                        tcwc_pkg::FL_EXT_W'(r_in_flight)
                        - $signed(tcwc_pkg::FL_EXT_W'(w_adv)));
                    n_last_ack    = r_ack;
                    n_dup_count   = '0;
                    n_window_base = r_ack;
                end else if (w_is_dup) begin
                    n_dup_count   = w_dup_inc;
                    n_window_base = r_ack;
                    if (w_dup_inc == tcwc_pkg::DUP_TRIGGER) begin
                        // Third duplicate: fast retransmit and enter recovery.
                        n_in_recovery    = 1'b1;
                        n_slow_threshold = w_halved;
                        n_window_q = tcwc_pkg::sat_q((tcwc_pkg::WIDE_W'(w_halved)
                            + tcwc_pkg::WIDE_W'(tcwc_pkg::RECOVERY_INFLATE))
                            << tcwc_pkg::FRAC_BITS);
                        n_rtx     = 1'b1;
                        n_rtx_seq = r_ack;
                    end else if (w_dup_inc > tcwc_pkg::DUP_TRIGGER) begin
                        n_window_q = tcwc_pkg::sat_q(tcwc_pkg::WIDE_W'(r_window_q)
                            + tcwc_pkg::WIDE_W'(tcwc_pkg::ONE_Q));
                    end
                end else if (r_op == tcwc_pkg::OP_TIMEOUT) begin
                    n_slow_threshold = w_halved;
                    n_window_q       = tcwc_pkg::ONE_Q;
                    n_in_flight      = '0;
                    n_in_recovery    = 1'b0;
                    n_dup_count      = '0;
                end
            end
            tcwc_pkg::S_DIV: begin
                n_rem = w_rem_ge
                        ? tcwc_pkg::Q_W'(w_rem_shift - {1'b0, r_window_q})
                        : tcwc_pkg::Q_W'(w_rem_shift);
                n_quot    = {r_quot[tcwc_pkg::Q_W-2:0], w_rem_ge};
                n_div_cnt = r_div_cnt + 1'b1;
            end
            tcwc_pkg::S_ACCUM: begin
                n_window_q = tcwc_pkg::sat_q(tcwc_pkg::WIDE_W'(r_window_q)
                                             + tcwc_pkg::WIDE_W'(r_quot));
            end
            tcwc_pkg::S_BURST: begin
                if (w_commit && w_send) begin
                    n_in_flight = tcwc_pkg::sat_flight(tcwc_pkg::FL_EXT_W'(r_in_flight)
                                  + $signed(tcwc_pkg::FL_EXT_W'(w_count)));
                end
            end
            default: ;
        endcase

        // A threshold write loads the working threshold at once; write it only while idle (not enforced).
        if (i_cfg_we && (i_cfg_index == tcwc_pkg::CFG_INITIAL_THRESHOLD)) begin
            n_slow_threshold = w_cfg_threshold;
        end
    end

    // Control and protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= tcwc_pkg::S_IDLE;
            r_total_segments <= '0;
            r_window_q       <= tcwc_pkg::ONE_Q;
            r_slow_threshold <= tcwc_pkg::INIT_THRESHOLD;
            r_dup_count      <= '0;
            r_in_recovery    <= 1'b0;
            r_last_ack       <= '0;
            r_window_base    <= '0;
            r_in_flight      <= '0;
            r_div_cnt        <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_window_q    <= n_window_q;
            r_dup_count   <= n_dup_count;
            r_in_recovery <= n_in_recovery;
            r_last_ack    <= n_last_ack;
            r_window_base <= n_window_base;
            r_in_flight   <= n_in_flight;
            r_div_cnt     <= n_div_cnt;
            r_slow_threshold <= n_slow_threshold;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcwc_pkg::CFG_TOTAL_SEGMENTS: begin
                        r_total_segments <= tcwc_pkg::SEQ_BITS'(i_cfg_data);
                    end
                    default: ;
                endcase
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Event, divider and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_evt.operation;
            r_ack <= i_evt.ack_number;
        end
        r_rtx     <= n_rtx;
        r_rtx_seq <= n_rtx_seq;
        r_rem     <= n_rem;
        r_quot    <= n_quot;
        if (w_commit) begin
            r_out_send_start     <= r_window_base;
            r_out_send_count     <= w_send ? w_count : '0;
            r_out_retransmit     <= r_rtx;
            r_out_retransmit_seq <= r_rtx_seq;
            r_out_window_size    <= w_win_int;
            r_out_threshold      <= r_slow_threshold;
        end
    end

    assign i_evt.ready          = w_in_ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.send_start     = r_out_send_start;
    assign o_res.send_count     = r_out_send_count;
    assign o_res.retransmit     = r_out_retransmit;
    assign o_res.retransmit_seq = r_out_retransmit_seq;
    assign o_res.window_size    = r_out_window_size;
    assign o_res.threshold      = r_out_threshold;

    // The threshold never drops below its floor.
    a_thr_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slow_threshold >= tcwc_pkg::THR_FLOOR)
        else $error("slow start threshold below floor");

    // A retransmit result carries the inflated recovery window.
    a_rtx_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.retransmit)
        |-> (o_res.window_size == o_res.threshold + tcwc_pkg::RECOVERY_INFLATE))
        else $error("recovery window does not match threshold");

    // The retransmitted segment is the base of the burst.
    a_rtx_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.retransmit) |-> (o_res.retransmit_seq == o_res.send_start))
        else $error("retransmit segment differs from window base");

    // Without a retransmit the segment field reads zero.
    a_rtx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.retransmit) |-> (o_res.retransmit_seq == '0))
        else $error("retransmit segment set without retransmit");

    // The divider hands over after its last iteration.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcwc_pkg::S_DIV && r_div_cnt == '1) |=> (r_state == tcwc_pkg::S_ACCUM))
        else $error("divider did not finish after the last iteration");

endmodule

>>> bench/tcp_congestion_window_control_unit_tb.sv
// Self-checking testbench of the congestion window control unit with a built-in Reno predictor.
`timescale 1ns / 1ps

module tcp_congestion_window_control_unit_tb;

    localparam logic [tcwc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int HALF_PERIOD  = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 48;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [tcwc_pkg::OP_W-1:0]     op;
        logic [tcwc_pkg::SEQ_BITS-1:0] ack;
    } t_congestion_event;

    typedef struct packed {
        logic [tcwc_pkg::SEQ_BITS-1:0] send_start;
        logic [tcwc_pkg::CNT_W-1:0]    send_count;
        logic                          retransmit;
        logic [tcwc_pkg::SEQ_BITS-1:0] retransmit_seq;
        logic [tcwc_pkg::INT_W-1:0]    window_size;
        logic [tcwc_pkg::THR_W-1:0]    threshold;
    } t_burst_report;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tcwc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [tcwc_pkg::CFG_W-1:0]     i_cfg_data;

    tcwc_evt_if evt_ch ();
    tcwc_res_if res_ch ();

    tcp_congestion_window_control_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_evt       (evt_ch),
        .o_res       (res_ch)
    );

    // Predictor state and its copy of the configuration.
    logic [tcwc_pkg::Q_W-1:0]      win_q;
    logic [tcwc_pkg::THR_W-1:0]    ssthresh;
    logic [tcwc_pkg::DUP_W-1:0]    dup_cnt;
    logic                          fast_rec;
    logic [tcwc_pkg::SEQ_BITS-1:0] last_acked;
    logic [tcwc_pkg::SEQ_BITS-1:0] base_seq;
    int                            flight;
    logic [tcwc_pkg::CNT_W-1:0]    seg_total;

    t_congestion_event event_backlog[$];
    t_burst_report     pending_reports[$];

    int failures = 0;
    int ack_cursor = 0;
    int burst_left;
    int gap_left;
    int hold_requests = 0;
    int holds_served;
    int hold_left;
    int stall_mode;
    int mode_left;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic logic [tcwc_pkg::Q_W-1:0] q_add(input logic [tcwc_pkg::Q_W-1:0] a,
                                                       input logic [tcwc_pkg::Q_W-1:0] b);
        logic [tcwc_pkg::Q_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[tcwc_pkg::Q_W] ? {tcwc_pkg::Q_W{1'b1}} : s[tcwc_pkg::Q_W-1:0];
    endfunction

    function automatic int clamp_flight(input int v);
        if (v > int'(tcwc_pkg::FLIGHT_MAX)) return int'(tcwc_pkg::FLIGHT_MAX);
        if (v < int'(tcwc_pkg::FLIGHT_MIN)) return int'(tcwc_pkg::FLIGHT_MIN);
        return v;
    endfunction

    function automatic logic [tcwc_pkg::THR_W-1:0] halved_ssthresh(
        input logic [tcwc_pkg::Q_W-1:0] w
    );
        if (w <= tcwc_pkg::FOUR_Q) return tcwc_pkg::THR_FLOOR;
        return tcwc_pkg::THR_W'(w >> (tcwc_pkg::FRAC_BITS + 1));
    endfunction

    // Applies one event to the predictor state and returns the burst it should report.
    function automatic t_burst_report reno_advance(
        input logic [tcwc_pkg::OP_W-1:0] op, input logic [tcwc_pkg::SEQ_BITS-1:0] ack
    );
        t_burst_report                 rpt;
        logic [tcwc_pkg::SEQ_BITS-1:0] adv;
        logic [63:0]                   quo;
        logic [tcwc_pkg::INT_W-1:0]    win_int;
        logic [tcwc_pkg::CNT_W-1:0]    cnt;
        logic [tcwc_pkg::CNT_W-1:0]    room;
        rpt = '0;
        if (op == tcwc_pkg::OP_ACK) begin
            if (ack > last_acked) begin
                adv = ack - last_acked;
                if (fast_rec) begin
                    win_q = tcwc_pkg::Q_W'(ssthresh) << tcwc_pkg::FRAC_BITS;
                    fast_rec = 1'b0;
                end else if (win_q[tcwc_pkg::Q_W-1:tcwc_pkg::FRAC_BITS] <= ssthresh) begin
                    win_q = q_add(win_q, tcwc_pkg::Q_W'(adv) << tcwc_pkg::FRAC_BITS);
                end else begin
                    // Avoidance step is advance / window, both in Q format.
                    quo = (64'(adv) << (2 * tcwc_pkg::FRAC_BITS)) / 64'(win_q);
                    if (quo > 64'(tcwc_pkg::Q_MAX)) quo = 64'(tcwc_pkg::Q_MAX);
                    win_q = q_add(win_q, quo[tcwc_pkg::Q_W-1:0]);
                end
                flight = clamp_flight(flight - int'(adv));
                last_acked = ack;
                dup_cnt = '0;
                base_seq = ack;
            end else if (ack == last_acked) begin
                if (dup_cnt != tcwc_pkg::DUP_MAX) dup_cnt = dup_cnt + 1'b1;
                base_seq = ack;
                if (dup_cnt == tcwc_pkg::DUP_TRIGGER) begin
                    fast_rec = 1'b1;
                    ssthresh = halved_ssthresh(win_q);
                    win_q = q_add(tcwc_pkg::Q_W'(ssthresh) << tcwc_pkg::FRAC_BITS,
                                  tcwc_pkg::Q_W'(tcwc_pkg::RECOVERY_INFLATE)
                                  << tcwc_pkg::FRAC_BITS);
                    rpt.retransmit = 1'b1;
                    rpt.retransmit_seq = base_seq;
                end else if (dup_cnt > tcwc_pkg::DUP_TRIGGER) begin
                    win_q = q_add(win_q, tcwc_pkg::ONE_Q);
                end
            end
        end else if (op == tcwc_pkg::OP_TIMEOUT) begin
            ssthresh = halved_ssthresh(win_q);
            win_q = tcwc_pkg::ONE_Q;
            flight = 0;
            fast_rec = 1'b0;
            dup_cnt = '0;
        end
        win_int = win_q[tcwc_pkg::Q_W-1:tcwc_pkg::FRAC_BITS];
        cnt = '0;
        if (flight < int'(win_int)) begin
            if (base_seq < seg_total) begin
                room = seg_total - base_seq;
                cnt = (win_int < room) ? win_int : room;
            end
            flight = clamp_flight(flight + int'(cnt));
        end
        rpt.send_start = base_seq;
        rpt.send_count = cnt;
        rpt.window_size = win_int;
        rpt.threshold = ssthresh;
        return rpt;
    endfunction

    task automatic log_failure(input string what);
        if (failures < MAX_REPORTS) $display("%0t: %s", $time, what);
        failures++;
    endtask

    task automatic queue_event(input logic [tcwc_pkg::OP_W-1:0] op, input int ack);
        t_congestion_event e;
        e.op = op;
        e.ack = ack[tcwc_pkg::SEQ_BITS-1:0];
        event_backlog.push_back(e);
    endtask

    // Random traffic: mostly advancing acknowledgments and duplicate runs, with noise mixed in.
    task automatic queue_traffic(input int n_events, input int max_jump, input int ack_ceiling);
        int k;
        int pick;
        int step;
        int run;
        k = 0;
        while (k < n_events) begin
            pick = $urandom_range(0, 99);
            if (pick < 55 && ack_cursor < ack_ceiling) begin
                step = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_jump)
                                                   : $urandom_range(1, 6);
                if (step > ack_ceiling - ack_cursor) step = ack_ceiling - ack_cursor;
                ack_cursor += step;
                queue_event(tcwc_pkg::OP_ACK, ack_cursor);
                k++;
            end else if (pick < 75) begin
                run = $urandom_range(1, 6);
                repeat (run) queue_event(tcwc_pkg::OP_ACK, ack_cursor);
                k += run;
            end else if (pick < 80) begin
                queue_event(tcwc_pkg::OP_ACK,
                            (ack_cursor > 0) ? $urandom_range(0, ack_cursor - 1) : 0);
                k++;
            end else if (pick < 88) begin
                queue_event(tcwc_pkg::OP_TIMEOUT, $urandom_range(0, 65535));
                k++;
            end else if (pick < 95) begin
                queue_event(tcwc_pkg::OP_START, $urandom_range(0, 65535));
                k++;
            end else begin
                queue_event(OP_UNUSED, $urandom_range(0, 65535));
                k++;
            end
        end
    endtask

    task automatic wait_idle();
        while (event_backlog.size() != 0 || evt_ch.valid || pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tcwc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcwc_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tcwc_pkg::CFG_TOTAL_SEGMENTS) begin
            seg_total = val;
        end else begin
            ssthresh = (val < tcwc_pkg::THR_FLOOR) ? tcwc_pkg::THR_FLOOR : val;
        end
    endtask

    // Event driver: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin : driver
        t_congestion_event nxt;
        logic busy;
        if (!i_rst_n) begin
            evt_ch.valid <= 1'b0;
            burst_left <= 1;
            gap_left <= 0;
        end else begin
            busy = evt_ch.valid && !evt_ch.ready;
            if (evt_ch.valid && evt_ch.ready) begin
                pending_reports.push_back(reno_advance(evt_ch.operation, evt_ch.ack_number));
            end
            if (!busy) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    evt_ch.valid <= 1'b0;
                end else if (event_backlog.size() != 0) begin
                    nxt = event_backlog.pop_front();
                    evt_ch.valid <= 1'b1;
                    evt_ch.operation <= nxt.op;
                    evt_ch.ack_number <= nxt.ack;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    evt_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: switches between stall patterns and honours long hold requests.
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            holds_served <= 0;
            hold_left <= 0;
            stall_mode <= 0;
            mode_left <= 0;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: begin
                    res_ch.ready <= 1'b1;
                end
                1: begin
                    res_ch.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    res_ch.ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // Result monitor: each transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_burst_report got;
        t_burst_report want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.send_start = res_ch.send_start;
            got.send_count = res_ch.send_count;
            got.retransmit = res_ch.retransmit;
            got.retransmit_seq = res_ch.retransmit_seq;
            got.window_size = res_ch.window_size;
            got.threshold = res_ch.threshold;
            if (pending_reports.size() == 0) begin
                log_failure("result transaction with no prediction waiting");
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    log_failure($sformatf({"mismatch: expected start %0d count %0d rtx %0b ",
                        "seq %0d win %0d thr %0d; got start %0d count %0d rtx %0b seq %0d ",
                        "win %0d thr %0d"},
                        want.send_start, want.send_count, want.retransmit,
                        want.retransmit_seq, want.window_size, want.threshold,
                        got.send_start, got.send_count, got.retransmit,
                        got.retransmit_seq, got.window_size, got.threshold));
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = tcwc_pkg::CFG_TOTAL_SEGMENTS;
        i_cfg_data = '0;
        win_q = tcwc_pkg::ONE_Q;
        ssthresh = tcwc_pkg::INIT_THRESHOLD;
        dup_cnt = '0;
        fast_rec = 1'b0;
        last_acked = '0;
        base_seq = '0;
        flight = 0;
        seg_total = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: nothing to send, three duplicates of zero enter recovery.
        queue_event(tcwc_pkg::OP_START, 0);
        queue_event(OP_UNUSED, 16'hFFFF);
        repeat (4) queue_event(tcwc_pkg::OP_ACK, 0);
        queue_event(tcwc_pkg::OP_ACK, 5);
        queue_event(tcwc_pkg::OP_TIMEOUT, 16'hAAAA);
        wait_idle();

        // A threshold written below the floor is raised to two.
        write_reg(tcwc_pkg::CFG_TOTAL_SEGMENTS, 16'd40);
        write_reg(tcwc_pkg::CFG_INITIAL_THRESHOLD, 16'd0);
        queue_event(tcwc_pkg::OP_START, 16'h5555);
        queue_event(tcwc_pkg::OP_ACK, 8);
        queue_event(tcwc_pkg::OP_ACK, 9);
        queue_event(tcwc_pkg::OP_ACK, 12);
        queue_event(tcwc_pkg::OP_ACK, 4);
        repeat (4) queue_event(tcwc_pkg::OP_ACK, 12);
        queue_event(tcwc_pkg::OP_ACK, 45);
        queue_event(tcwc_pkg::OP_START, 0);
        queue_event(tcwc_pkg::OP_TIMEOUT, 0);
        ack_cursor = 45;
        wait_idle();

        write_reg(tcwc_pkg::CFG_TOTAL_SEGMENTS, 16'd120);
        write_reg(tcwc_pkg::CFG_INITIAL_THRESHOLD, 16'd1);
        queue_traffic(30, 200, 20000);
        wait_idle();

        // The receiver holds off for a long stretch while events keep coming.
        write_reg(tcwc_pkg::CFG_TOTAL_SEGMENTS, 16'd400);
        write_reg(tcwc_pkg::CFG_INITIAL_THRESHOLD, 16'd16);
        hold_requests <= hold_requests + 1;
        queue_traffic(40, 40, 20000);
        wait_idle();

        // A very long duplicate run drives the duplicate count into saturation.
        write_reg(tcwc_pkg::CFG_TOTAL_SEGMENTS, 16'd0);
        write_reg(tcwc_pkg::CFG_INITIAL_THRESHOLD, 16'hFFFF);
        queue_traffic(10, 16, 20000);
        repeat (258) queue_event(tcwc_pkg::OP_ACK, ack_cursor);
        queue_traffic(10, 16, 20000);
        wait_idle();

        write_reg(tcwc_pkg::CFG_TOTAL_SEGMENTS, 16'd3000);
        write_reg(tcwc_pkg::CFG_INITIAL_THRESHOLD, 16'd40);
        queue_traffic(20, 64, 20000);
        wait_idle();

        // Largest settings: huge advances saturate the window before recovery halves it.
        write_reg(tcwc_pkg::CFG_TOTAL_SEGMENTS, 16'hFFFF);
        write_reg(tcwc_pkg::CFG_INITIAL_THRESHOLD, 16'hFFFF);
        queue_event(tcwc_pkg::OP_ACK, 30000);
        queue_event(tcwc_pkg::OP_ACK, 52000);
        queue_event(tcwc_pkg::OP_ACK, 65000);
        queue_event(tcwc_pkg::OP_ACK, 65400);
        repeat (4) queue_event(tcwc_pkg::OP_ACK, 65400);
        ack_cursor = 65400;
        queue_traffic(20, 30, 65535);
        queue_event(tcwc_pkg::OP_ACK, 65535);
        repeat (3) queue_event(tcwc_pkg::OP_ACK, 65535);
        queue_event(tcwc_pkg::OP_TIMEOUT, 16'hFFFF);
        queue_event(tcwc_pkg::OP_START, 0);
        ack_cursor = 65535;
        wait_idle();

        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/tcwc_pkg.sv
rtl/tcwc_evt_if.sv
rtl/tcwc_res_if.sv
rtl/tcp_congestion_window_control_unit.sv
bench/tcp_congestion_window_control_unit_tb.sv
